FILE: rtl/core/jac_pkg.sv
// ----------------------------------------------------------------------------
// jac_pkg: joystick axis conditioner shared definitions
// Field widths, fixed-point constants, register indexes and reset values.
// ----------------------------------------------------------------------------
package jac_pkg;

	// stream field widths
	localparam int AxisW   = 3;
	localparam int RawW    = 16;
	localparam int OutW    = 17;

	// fixed-point formats
	localparam int SmoothW = 24;   // Q0.23 smoothed value
	localparam int MulAW   = 25;   // signed operand A of the shared multiplier
	localparam int MulBW   = 17;   // signed operand B of the shared multiplier
	localparam int ProdW   = MulAW + MulBW;

	// configuration register widths
	localparam int WeightW = 16;
	localparam int DeadW   = 15;
	localparam int GainW   = 14;
	localparam int CfgW    = 16;
	localparam int CfgIdxW = 2;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_WEIGHT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_DEAD   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_GAIN   = 2'd2;

	// reset values
	localparam logic [WeightW-1:0] WEIGHT_RST = 16'd6554;
	localparam logic [DeadW-1:0]   DEAD_RST   = 15'd3277;
	localparam logic [GainW-1:0]   GAIN_RST   = 14'd5461;

	// limits
	localparam logic [WeightW-1:0] WEIGHT_ONE = 16'd32768;
	localparam int                 OUT_MAX    = 32768;
	localparam int                 S_MAX      = 8388607;
	localparam int                 S_MIN      = -8388608;

	localparam int AXIS_COUNT_DEF = 8;

endpackage

FILE: rtl/core/joystick_axis_conditioner_unit.sv
// ----------------------------------------------------------------------------
// joystick_axis_conditioner_unit: smoothing, dead zone and gain per axis
// Exponential smoothing of each axis in Q0.23, then dead zone, gain and
// saturation to +-1.0, all on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
// Channel   | Dir | Beat contents (lowest bit first)
// ----------|-----|-------------------------------------------------------
// s_axis    | in  | tuser: axis_number[2:0]; tdata: raw_sample[15:0]
// m_axis    | out | tuser: axis_number_out[2:0]; tdata: conditioned_value[16:0]
// cfg       | in  | cfg_index selects weight / dead zone / gain, cfg_data
//
// The store read is issued at the accepting edge; the result is loaded into
// the output register after the steps smoothing product, update and dead
// zone, gain product, then round and saturate. s_axis_tready is high only
// while the sequencer is idle, from the cycle after the load, so a new beat
// is taken only after the previous one has been loaded. The result waits
// in the output register; a new beat may be accepted while it waits, and
// the sequencer holds in its last step only while the previous result is unread.
// Reset clears the sequencer, the output valid, the configuration registers to
// their defaults and the store's per-entry valid bits at once.
// ----------------------------------------------------------------------------
module joystick_axis_conditioner_unit
	import jac_pkg::*;
#(
	parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	// input stream
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [15:0]        s_axis_tdata,  // raw_sample[15:0]
	input  logic [2:0]         s_axis_tuser,  // axis_number[2:0]
	// output stream
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [23:0]        m_axis_tdata,  // conditioned_value[16:0], zeros above
	output logic [2:0]         m_axis_tuser   // axis_number_out[2:0]
);

	localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;  // smoothing product
	localparam logic [2:0] ST_UPD  = 3'd2;  // new smoothed value, dead zone
	localparam logic [2:0] ST_MUL2 = 3'd3;  // gain product
	localparam logic [2:0] ST_FIN  = 3'd4;  // round, saturate, load output

	logic [2:0] state_q;

	// configuration registers
	logic [WeightW-1:0] weight_q;
	logic [DeadW-1:0]   dead_q;
	logic [GainW-1:0]   gain_q;

	// item registers
	logic [AxisW-1:0]          axis_q;
	logic signed [RawW-1:0]    raw_q;
	logic                      inrange_q;
	logic signed [SmoothW-1:0] s_q;
	logic                      neg_q;
	logic                      zero_q;
	logic [SmoothW-1:0]        m_q;

	// output register
	logic                      out_valid_q;
	logic [AxisW-1:0]          out_axis_q;
	logic signed [OutW-1:0]    out_value_q;

	logic accept;
	logic in_rng;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic st_we;
	logic signed [SmoothW-1:0] st_rdata;

	logic mul_en;
	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic signed [ProdW-1:0] prod;

	logic [WeightW-1:0]        w_eff;
	logic signed [SmoothW-1:0] x23;
	logic signed [ProdW-1:0]   rnd1;
	logic signed [27:0]        s_sum;
	logic signed [SmoothW-1:0] s_new;
	logic [SmoothW-1:0]        mag;
	logic [SmoothW-1:0]        dz23;
	logic [ProdW-1:0]          rnd2;
	logic [21:0]               q_full;
	logic [OutW-1:0]           q_sat;
	logic signed [OutW-1:0]    result;
	logic                      out_load;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_rng        = (32'(s_axis_tuser) < AXIS_COUNT);
	assign rd_addr       = AW'(s_axis_tuser);
	assign wr_addr       = AW'(axis_q);
	assign st_we         = (state_q == ST_UPD) && inrange_q;
	assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	// configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RST;
			dead_q   <= DEAD_RST;
			gain_q   <= GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WEIGHT: weight_q <= cfg_data[WeightW-1:0];
				REG_DEAD:   dead_q   <= cfg_data[DeadW-1:0];
				REG_GAIN:   gain_q   <= cfg_data[GainW-1:0];
				default: ;
			endcase
		end
	end

	jac_store #(
		.DEPTH(AXIS_COUNT),
		.AW   (AW)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.rd_en (accept && in_rng),
		.raddr (rd_addr),
		.rdata (st_rdata),
		.we    (st_we),
		.waddr (wr_addr),
		.wdata (s_new)
	);

	// weight above one acts as one
	assign w_eff = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign x23   = {raw_q, 8'd0};

	// operand select for the shared multiplier:
	// first pass (x - s) * w, second pass (|s| - dz) * gain
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_MUL1: begin
				mul_en = 1'b1;
				mul_a  = MulAW'(x23) - MulAW'(st_rdata);
				mul_b  = signed'({1'b0, w_eff});
			end
			ST_MUL2: begin
				mul_en = 1'b1;
				mul_a  = signed'({1'b0, m_q});
				mul_b  = signed'(MulBW'(gain_q));
			end
			default: ;
		endcase
	end

	jac_mult u_mult (
		.clk   (clk),
		.en    (mul_en),
		.op_a  (mul_a),
		.op_b  (mul_b),
		.prod_q(prod)
	);

	// s_new = s + floor((prod + 2^14) / 2^15), clamped to 24 bits
	assign rnd1  = prod + ProdW'(16384);
	assign s_sum = 28'(s_q) + 28'(signed'(rnd1[ProdW-1:15]));
	always_comb begin
		if (s_sum > 28'(S_MAX)) begin
			s_new = SmoothW'(S_MAX);
		end else if (s_sum < 28'(S_MIN)) begin
			s_new = SmoothW'(S_MIN);
		end else begin
			s_new = s_sum[SmoothW-1:0];
		end
	end

	assign mag  = s_new[SmoothW-1] ? SmoothW'(-s_new) : SmoothW'(s_new);
	assign dz23 = {1'b0, dead_q, 8'd0};

	// gain product rounded half up to Q0.15, then saturate and restore the sign
	assign rnd2   = prod + ProdW'(1 << 19);
	assign q_full = rnd2[41:20];
	assign q_sat  = (q_full > 22'(OUT_MAX)) ? OutW'(OUT_MAX) : q_full[OutW-1:0];
	always_comb begin
		if (!inrange_q || zero_q) begin
			result = '0;
		end else if (neg_q) begin
			result = signed'(OutW'(0) - q_sat);
		end else begin
			result = signed'(q_sat);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FIN;
				ST_FIN:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload: capture on accept, advance through the steps
	always_ff @(posedge clk) begin
		if (accept) begin
			axis_q    <= s_axis_tuser;
			raw_q     <= signed'(s_axis_tdata);
			inrange_q <= in_rng;
		end
		if (state_q == ST_MUL1) begin
			s_q <= st_rdata;
		end
		if (state_q == ST_UPD) begin
			neg_q  <= s_new[SmoothW-1];
			zero_q <= (mag < dz23);
			m_q    <= mag - dz23;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_axis_q  <= axis_q;
			out_value_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_axis_q;
	assign m_axis_tdata  = {7'd0, out_value_q};

`ifndef SYNTH
	// a new result appears only out of the last sequencer step
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_FIN)
		else $error("output valid rose outside the final step");

	// an accepted beat always starts the smoothing pass
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == ST_MUL1)
		else $error("accepted beat did not start the sequencer");

	// the store is written only in the update step of an in-range axis
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> state_q == ST_UPD && inrange_q)
		else $error("store written outside the update step");

	// the delivered value stays within plus or minus one
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_value_q <= 17'sd32768 && out_value_q >= -17'sd32768)
		else $error("conditioned value out of range");
`endif

endmodule

FILE: rtl/core/jac_mult.sv
// ----------------------------------------------------------------------------
// jac_mult: shared signed multiplier
// One 25x17 signed multiply per enabled cycle, product registered.
// ----------------------------------------------------------------------------
module jac_mult
	import jac_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [MulAW-1:0]  op_a,
	input  logic signed [MulBW-1:0]  op_b,
	output logic signed [ProdW-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= ProdW'(op_a) * ProdW'(op_b);
		end
	end

endmodule

FILE: rtl/core/jac_store.sv
// ----------------------------------------------------------------------------
// jac_store: per-axis smoothed value store
// Single write port, one registered read port; entries never written read 0.
// ----------------------------------------------------------------------------
module jac_store
	import jac_pkg::*;
#(
	parameter int DEPTH = AXIS_COUNT_DEF,
	parameter int AW    = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [AW-1:0]             raddr,
	output logic signed [SmoothW-1:0] rdata,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic signed [SmoothW-1:0] wdata
);

	logic signed [SmoothW-1:0] mem [DEPTH];
	logic [DEPTH-1:0]          valid_q;
	logic signed [SmoothW-1:0] rdata_q;
	logic                      rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	// an entry not yet written reads as zero through its cleared valid bit
	assign rdata = rvalid_q ? rdata_q : '0;

endmodule
